// ===== rtl/b2da_pkg.sv =====
// Package: shared constants and controller/datapath interface types.
`default_nettype none
package b2da_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGITS  = 10;
  localparam int unsigned IDX_W   = $clog2(DIGITS);
  localparam int unsigned QUOT_W  = 29;
  localparam int unsigned SHIFT   = 35;

  // floor(n / 10) == (n * RECIP) >> SHIFT, exact for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP      = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic rd_zero;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// Top level: 32-bit binary to decimal ASCII digit converter.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+---------------------------------
//   input    | value                      | taken when start && !busy
//   result   | digit_char, last           | digit_strobe, one cycle, no stall
//
// A number of d digits (1..10) runs the multiply/split loop once per digit
// through the single reciprocal multiplier, then outputs its digits. Digits
// leave most significant first; last marks the final one. Reset (rst,
// synchronous) returns to idle and drops the strobe. The receiver cannot
// stall; busy holds off new items.
`default_nettype none
module binary_to_decimal_ascii_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
  output logic                               digit_strobe,
  output logic      [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                               last
);
  import b2da_pkg::*;

  cmd_t    cmd;
  status_t status;

  b2da_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  b2da_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .digit_strobe (digit_strobe),
    .digit_char   (digit_char),
    .last         (last)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item taken but not busy");
  a_digits_contiguous: assert property (@(posedge clk) disable iff (rst)
    digit_strobe && !last |=> digit_strobe) else $error("gap inside a number");
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    digit_strobe && last |=> !digit_strobe) else $error("digit after last");

endmodule
`default_nettype wire

// ===== rtl/b2da_ctrl.sv =====
// Controller: sequences multiply, digit split and digit output per item.
`default_nettype none
module b2da_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  b2da_pkg::status_t      status,
  output b2da_pkg::cmd_t         cmd
);
  import b2da_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = status.q_zero ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.rd_zero) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_MUL) else $error("load did not start multiply");
  a_mul_then_div: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.div) else $error("multiply not followed by split");
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.rd_zero |=> !busy) else $error("emit did not finish");

endmodule
`default_nettype wire

// ===== rtl/b2da_dp.sv =====
// Datapath: reciprocal divide by ten, digit buffer and output register.
`default_nettype none
module b2da_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  b2da_pkg::cmd_t                     cmd,
  output b2da_pkg::status_t                  status,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
  output logic                               digit_strobe,
  output logic      [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                               last
);
  import b2da_pkg::*;

  logic [VALUE_W-1:0]   n;
  logic [QUOT_W-1:0]    q;
  logic [2*VALUE_W-1:0] prod;
  logic [3:0]           q10_lo;
  logic [3:0]           rem;
  logic [IDX_W-1:0]     cnt;
  logic [IDX_W-1:0]     rd;
  logic [3:0]           dbuf [DIGITS];

  assign prod   = n * RECIP;
  // low nibble of q*10 is all the remainder needs
  assign q10_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign rem    = n[3:0] - q10_lo;

  assign status.q_zero  = (q == '0);
  assign status.rd_zero = (rd == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= value;
    end else if (cmd.div) begin
      n <= {{(VALUE_W-QUOT_W){1'b0}}, q};
    end
    if (cmd.mul) begin
      q <= prod[SHIFT +: QUOT_W];
    end
    if (cmd.div) begin
      dbuf[cnt] <= rem;
      rd        <= cnt;
    end else if (cmd.emit) begin
      rd <= rd - 1'b1;
    end
    if (cmd.emit) begin
      digit_char <= ASCII_ZERO + {2'b00, dbuf[rd]};
      last       <= (rd == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      digit_strobe <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.div) begin
        cnt <= cnt + 1'b1;
      end
      digit_strobe <= cmd.emit;
    end
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    digit_strobe |-> $past(cmd.emit)) else $error("strobe without emit");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    cmd.div && !$past(rst) |=> cnt == $past(cnt) + 1'b1) else $error("digit count slip");
  a_load_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cnt == '0) else $error("count not cleared on load");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for binary_to_decimal_ascii_unit: directed and random numbers, digits checked per item.
`default_nettype none
module tb;
  import b2da_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int DIR_N      = 20;
  localparam int RAND_N     = 250;
  localparam int CALM_N     = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } digit_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               digit_strobe;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;

  digit_t pending_digits[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     gaps_on = 1'b1;

  logic [VALUE_W-1:0] dir_val [DIR_N] = '{
    32'd0, 32'hFFFF_FFFF, 32'd1, 32'd10, 32'd1000000000,
    32'd9, 32'd99, 32'd100, 32'd999999999, 32'hFFFF_FFFE,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
    32'hFFFF_0000, 32'd4000000000, 32'd12345, 32'd1000000, 32'd7
  };
  string dir_txt [DIR_N] = '{
    "0", "4294967295", "1", "10", "1000000000",
    "", "", "", "", "",
    "", "", "", "", "",
    "", "", "", "", ""
  };

  binary_to_decimal_ascii_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .digit_strobe (digit_strobe),
    .digit_char   (digit_char),
    .last         (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // decimal digits of n, most significant first
  task automatic queue_digits(input logic [VALUE_W-1:0] n);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         rev [DIGITS];
    int                 cnt;
    digit_t             d;
    rest = n;
    cnt = 0;
    if (rest == 0) begin
      rev[0] = 4'd0;
      cnt = 1;
    end else begin
      while (rest != 0 && cnt < DIGITS) begin
        rev[cnt] = 4'(rest % 10);
        rest = rest / 10;
        cnt++;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      d.ch  = ASCII_ZERO + CHAR_W'(rev[cnt-1-k]);
      d.fin = (k == cnt - 1);
      pending_digits.push_back(d);
    end
  endtask

  task automatic queue_text(input string txt);
    byte    b;
    digit_t d;
    for (int k = 0; k < txt.len(); k++) begin
      b = txt[k];
      d.ch  = b[CHAR_W-1:0];
      d.fin = (k == txt.len() - 1);
      pending_digits.push_back(d);
    end
  endtask

  task automatic send_number(input logic [VALUE_W-1:0] v, input string txt);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (txt.len() != 0) queue_text(txt);
    else queue_digits(v);
  endtask

  always @(posedge clk) begin
    if (!rst && digit_strobe) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit", digit_char, -1);
      end else begin
        if (digit_char !== pending_digits[0].ch)
          report_mismatch("digit_char", digit_char, pending_digits[0].ch);
        if (last !== pending_digits[0].fin)
          report_mismatch("last", last, pending_digits[0].fin);
        void'(pending_digits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || digit_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int                 sel;
    int                 nd;
    longint unsigned    lo;
    longint unsigned    hi;
    logic [VALUE_W-1:0] v;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) send_number(dir_val[i], dir_txt[i]);

    for (int i = 0; i < RAND_N; i++) begin
      if (i == RAND_N - CALM_N) gaps_on = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        v = $urandom;
      end else begin
        nd = $urandom_range(1, DIGITS);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = (nd == DIGITS) ? 64'hFFFF_FFFF : lo * 10 - 1;
        if (nd == 1) lo = 0;
        v = $urandom_range(hi[31:0], lo[31:0]);
      end
      send_number(v, "");
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_digits.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== binary_to_decimal_ascii_unit.f =====
rtl/b2da_pkg.sv
rtl/b2da_ctrl.sv
rtl/b2da_dp.sv
rtl/binary_to_decimal_ascii_unit.sv
verif/tb.sv
